@@ rtl/rmd_pkg.sv @@
// Shared types, constants, step tables and round functions for the RIPEMD-160 core.
// Used by every module in rtl/.
package rmd_pkg;

    localparam int NUM_STEPS = 80;
    localparam int LEN_W     = 61;

    typedef logic [31:0] word_t;
    typedef logic [6:0]  step_t;

    localparam step_t       LAST_STEP      = step_t'(NUM_STEPS - 1);
    localparam logic [2:0]  FULL_BYTES     = 3'd4;
    localparam logic [2:0]  WORD_LAST      = 3'd4;
    localparam logic [3:0]  BLOCK_LAST     = 4'd15;
    // a pad byte in word 14 or 15 leaves no room for the length
    localparam logic [3:0]  PAD_LIMIT_WORD = 4'd13;
    localparam logic [3:0]  LEN_LO_WORD    = 4'd14;
    localparam word_t       PAD_WORD       = 32'h0000_0080;

    localparam word_t IV [5] = '{
        32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
    };
    localparam word_t K_L [5] = '{
        32'h0000_0000, 32'h5a82_7999, 32'h6ed9_eba1, 32'h8f1b_bcdc, 32'ha953_fd4e
    };
    localparam word_t K_R [5] = '{
        32'h50a2_8be6, 32'h5c4d_d124, 32'h6d70_3ef3, 32'h7a6d_76e9, 32'h0000_0000
    };

    localparam logic [3:0] SEL_L [80] = '{
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
        7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
        3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
        1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
        4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13
    };
    localparam logic [3:0] SEL_R [80] = '{
        5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
        6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
        15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
        8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
        12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11
    };
    localparam logic [4:0] ROT_L [80] = '{
        11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
        7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
        11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
        11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
        9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6
    };
    localparam logic [4:0] ROT_R [80] = '{
        8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
        9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
        9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
        15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
        8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11
    };

    // one queued message word, already masked and padded if partial
    typedef struct packed {
        word_t      data;
        logic [2:0] nbytes;
        logic       last;
    } item_t;

    // how the compression unit sees the block words
    typedef struct packed {
        logic             mask_en;  // words above lim read as zero
        logic             len_en;   // words 14/15 read as bit length
        logic             zero_en;  // all data words read as zero
        logic [3:0]       lim;
        logic [LEN_W-1:0] len;
    } comp_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_COMP = 4'b0100,
        S_OUT  = 4'b1000
    } back_state_t;

    typedef enum logic [1:0] {
        AFT_IDLE,
        AFT_PAD,
        AFT_ZERO,
        AFT_OUT
    } after_t;

    function automatic word_t rotl(input word_t v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        return d[63:32];
    endfunction

    function automatic word_t mix(input logic [2:0] g, input word_t x, input word_t y,
                                  input word_t z);
        word_t r;
        case (g)
            3'd0:    r = x ^ y ^ z;
            3'd1:    r = (x & y) | (~x & z);
            3'd2:    r = (x | ~y) ^ z;
            3'd3:    r = (x & z) | (y & ~z);
            default: r = x ^ (y | ~z);
        endcase
        return r;
    endfunction

endpackage

@@ rtl/rmd_front.sv @@
// Front end: accepts message words, masks and pads a partial last word,
// and holds them in a two-entry queue. Depends on rmd_pkg.
module rmd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [31:0]    data_word,
    input  logic [2:0]     byte_count,
    input  logic           last_word,
    output logic           q_valid,
    input  logic           q_take,
    output rmd_pkg::item_t q_item
);
    import rmd_pkg::*;

    item_t      slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    item_t      cls;
    logic       push, pop;

    // classify: only a last word may be partial; counts above four mean four
    always_comb
    begin
        cls.last   = last_word;
        cls.nbytes = (!last_word || byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
        case (cls.nbytes)
            3'd0:    cls.data = PAD_WORD;
            3'd1:    cls.data = {16'h0000, 8'h80, data_word[7:0]};
            3'd2:    cls.data = {8'h00, 8'h80, data_word[15:0]};
            3'd3:    cls.data = {8'h80, data_word[23:0]};
            default: cls.data = data_word;
        endcase
    end

    assign in_stall = cnt_reg[1];
    assign push     = in_valid && !in_stall;
    assign q_valid  = cnt_reg != 2'd0;
    assign pop      = q_valid && q_take;
    assign q_item   = slot_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/rmd_comp.sv @@
// Compression unit: 16-word block memory, both lines advance one step per cycle,
// chaining value with final feed-forward. Depends on rmd_pkg.
module rmd_comp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                reinit,
    input  rmd_pkg::comp_cfg_t  cfg,
    input  logic                wr_en,
    input  logic [3:0]          wr_addr,
    input  rmd_pkg::word_t      wr_data,
    output logic                done,
    output logic [4:0][31:0]    chain
);
    import rmd_pkg::*;

    word_t           mem [16];
    word_t           raw_l_reg, raw_r_reg;
    logic [3:0]      idx_l_reg, idx_r_reg;
    step_t           step_reg;
    logic            busy_reg, fin_reg, done_reg;
    word_t           al_reg, bl_reg, cl_reg, dl_reg, el_reg;
    word_t           ar_reg, br_reg, cr_reg, dr_reg, er_reg;
    logic [4:0][31:0] chain_reg;
    step_t           rd_step;
    logic [3:0]      rd_l, rd_r;
    logic [2:0]      grp, grp_r;
    word_t           x_l, x_r, t_l, t_r;

    // substitute padding zeros and the bit length for stale block words
    function automatic word_t blk_word(input logic [3:0] idx, input word_t raw,
                                       input comp_cfg_t c);
        word_t w;
        if (c.len_en && idx >= LEN_LO_WORD)
        begin
            w = (idx == LEN_LO_WORD) ? {c.len[28:0], 3'b000} : c.len[LEN_W-1:29];
        end
        else if (c.zero_en || (c.mask_en && idx > c.lim))
        begin
            w = '0;
        end
        else
        begin
            w = raw;
        end
        return w;
    endfunction

    // read one step ahead so block data arrives registered
    assign rd_step = (busy_reg && step_reg != LAST_STEP) ? step_reg + step_t'(1) : '0;
    assign rd_l    = SEL_L[rd_step];
    assign rd_r    = SEL_R[rd_step];

    // a word written in the start cycle is forwarded to the first read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        raw_l_reg <= (wr_en && wr_addr == rd_l) ? wr_data : mem[rd_l];
        raw_r_reg <= (wr_en && wr_addr == rd_r) ? wr_data : mem[rd_r];
        idx_l_reg <= rd_l;
        idx_r_reg <= rd_r;
    end

    // one step of each line
    always_comb
    begin
        grp   = step_reg[6:4];
        grp_r = 3'd4 - grp;
        x_l   = blk_word(idx_l_reg, raw_l_reg, cfg);
        x_r   = blk_word(idx_r_reg, raw_r_reg, cfg);
        t_l   = rotl(al_reg + mix(grp, bl_reg, cl_reg, dl_reg) + x_l + K_L[grp],
                     ROT_L[step_reg]) + el_reg;
        t_r   = rotl(ar_reg + mix(grp_r, br_reg, cr_reg, dr_reg) + x_r + K_R[grp],
                     ROT_R[step_reg]) + er_reg;
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            {al_reg, bl_reg, cl_reg, dl_reg, el_reg} <=
                {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3], chain_reg[4]};
            {ar_reg, br_reg, cr_reg, dr_reg, er_reg} <=
                {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3], chain_reg[4]};
        end
        else if (busy_reg)
        begin
            al_reg <= el_reg;
            el_reg <= dl_reg;
            dl_reg <= rotl(cl_reg, 5'd10);
            cl_reg <= bl_reg;
            bl_reg <= t_l;
            ar_reg <= er_reg;
            er_reg <= dr_reg;
            dr_reg <= rotl(cr_reg, 5'd10);
            cr_reg <= br_reg;
            br_reg <= t_r;
        end
    end

    // step sequencing and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            chain_reg <= {IV[4], IV[3], IV[2], IV[1], IV[0]};
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + step_t'(1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg)
            begin
                chain_reg[0] <= chain_reg[1] + cl_reg + dr_reg;
                chain_reg[1] <= chain_reg[2] + dl_reg + er_reg;
                chain_reg[2] <= chain_reg[3] + el_reg + ar_reg;
                chain_reg[3] <= chain_reg[4] + al_reg + br_reg;
                chain_reg[4] <= chain_reg[0] + bl_reg + cr_reg;
            end
            else if (reinit)
            begin
                chain_reg <= {IV[4], IV[3], IV[2], IV[1], IV[0]};
            end
        end
    end

    assign done  = done_reg;
    assign chain = chain_reg;

endmodule

@@ rtl/rmd_back.sv @@
// Back end: writes queued words into the block, sequences full-block and padding
// compressions, and streams the digest. Depends on rmd_pkg and rmd_comp.
module rmd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rmd_pkg::item_t q_item,
    output logic           q_take,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [31:0]    digest_word,
    output logic [2:0]     word_index,
    output logic           digest_last
);
    import rmd_pkg::*;

    back_state_t      state_reg, state_next;
    after_t           after_reg, after_next;
    logic [3:0]       pos_reg, pos_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             mask_reg, mask_next, lenen_reg, lenen_next, zero_reg, zero_next;
    logic [3:0]       lim_reg, lim_next;
    logic [2:0]       oidx_reg, oidx_next;
    logic             ov_reg, ov_next, olast_reg, olast_next;
    word_t            oword_reg, oword_next;
    logic [2:0]       oi_reg, oi_next;
    logic             start, reinit, wr_en, done;
    word_t            wr_data;
    comp_cfg_t        ccfg;
    logic [4:0][31:0] chain;

    assign ccfg = '{mask_en: mask_reg, len_en: lenen_reg, zero_en: zero_reg,
                    lim: lim_reg, len: len_reg};

    rmd_comp u_comp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .reinit  (reinit),
        .cfg     (ccfg),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .done    (done),
        .chain   (chain)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        mask_next  = mask_reg;
        lenen_next = lenen_reg;
        zero_next  = zero_reg;
        lim_next   = lim_reg;
        oidx_next  = oidx_reg;
        ov_next    = ov_reg && out_stall;
        olast_next = olast_reg;
        oword_next = oword_reg;
        oi_next    = oi_reg;
        q_take     = 1'b0;
        start      = 1'b0;
        reinit     = 1'b0;
        wr_en      = 1'b0;
        wr_data    = q_item.data;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take   = 1'b1;
                    wr_en    = 1'b1;
                    len_next = len_reg + LEN_W'(q_item.nbytes);
                    if (q_item.nbytes == FULL_BYTES)
                    begin
                        pos_next = pos_reg + 4'd1;
                        if (pos_reg == BLOCK_LAST)
                        begin
                            start      = 1'b1;
                            mask_next  = 1'b0;
                            lenen_next = 1'b0;
                            zero_next  = 1'b0;
                            after_next = q_item.last ? AFT_PAD : AFT_IDLE;
                            state_next = S_COMP;
                        end
                        else if (q_item.last)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else
                    begin
                        // partial last word carries its own pad byte
                        start      = 1'b1;
                        mask_next  = 1'b1;
                        zero_next  = 1'b0;
                        lim_next   = pos_reg;
                        lenen_next = pos_reg <= PAD_LIMIT_WORD;
                        after_next = (pos_reg <= PAD_LIMIT_WORD) ? AFT_OUT : AFT_ZERO;
                        state_next = S_COMP;
                    end
                end
            end
            S_PAD:
            begin
                wr_en      = 1'b1;
                wr_data    = PAD_WORD;
                start      = 1'b1;
                mask_next  = 1'b1;
                zero_next  = 1'b0;
                lim_next   = pos_reg;
                lenen_next = pos_reg <= PAD_LIMIT_WORD;
                after_next = (pos_reg <= PAD_LIMIT_WORD) ? AFT_OUT : AFT_ZERO;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                if (done)
                begin
                    case (after_reg)
                        AFT_PAD:  state_next = S_PAD;
                        AFT_ZERO:
                        begin
                            // length-only block
                            start      = 1'b1;
                            mask_next  = 1'b0;
                            zero_next  = 1'b1;
                            lenen_next = 1'b1;
                            after_next = AFT_OUT;
                        end
                        AFT_OUT:
                        begin
                            oidx_next  = '0;
                            state_next = S_OUT;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oword_next = chain[oidx_reg];
                    oi_next    = oidx_reg;
                    olast_next = oidx_reg == WORD_LAST;
                    if (oidx_reg == WORD_LAST)
                    begin
                        reinit     = 1'b1;
                        pos_next   = '0;
                        len_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= AFT_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            mask_reg  <= 1'b0;
            lenen_reg <= 1'b0;
            zero_reg  <= 1'b0;
            lim_reg   <= '0;
            oidx_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            mask_reg  <= mask_next;
            lenen_reg <= lenen_next;
            zero_reg  <= zero_next;
            lim_reg   <= lim_next;
            oidx_reg  <= oidx_next;
            ov_reg    <= ov_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        oword_reg <= oword_next;
        oi_reg    <= oi_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = ov_reg;
    assign digest_word = oword_reg;
    assign word_index  = oi_reg;
    assign digest_last = olast_reg;

endmodule

@@ rtl/ripemd160_hash_core.sv @@
// RIPEMD-160 hash core top level: front queue plus compression back end.
// Depends on rmd_pkg, rmd_front, rmd_back.
//
// Input channel (in_valid/in_stall): one little-endian message word per item,
// first byte in bits 7:0. byte_count is used only with last_word set (0..4,
// larger means 4); unused bytes of a partial last word are ignored.
// Output channel (out_valid/out_stall): after the last word, five items carry
// the digest words, word_index 0..4, digest_last on the fifth.
// A two-entry queue separates the input from the compression engine.
// Flow: a word that does not complete a block is written straight into the
// block; the sixteenth word of a block starts an 80-step compression (one
// step of both lines per cycle) plus feed-forward and handoff, during which
// no further word is taken. The last word adds one or two compressions and
// then the five digest items.
// A stalled output holds its word; the engine waits and the queue backs up to
// raise in_stall. Reset clears the queue, the length and the block position
// and loads the standard initial value; after each digest the core restarts.
module ripemd160_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);
    import rmd_pkg::*;

    logic  q_valid, q_take;
    item_t q_item;

    rmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .q_valid    (q_valid),
        .q_take     (q_take),
        .q_item     (q_item)
    );

    rmd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_last (digest_last)
    );

    // engine only pops a present entry
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid)
        else $error("queue popped while empty");

    // only a last word may be partial
    a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_item.nbytes != FULL_BYTES) |-> (q_item.last && q_item.nbytes < FULL_BYTES))
        else $error("partial word not marked last");

    // final flag matches the fifth digest word
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digest_last == (word_index == WORD_LAST)))
        else $error("digest_last out of step with word_index");

endmodule

@@ bench/ripemd160_hash_core_test.sv @@
// Self-checking bench for ripemd160_hash_core: directed and random messages are
// hashed by a behavioral RIPEMD-160 model and compared word by word with the digest items.
// Depends on rmd_pkg and the ripemd160_hash_core RTL.
module ripemd160_hash_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rmd_pkg::*;

    typedef struct {
        word_t      data;
        logic [2:0] nbytes;
        logic       last;
        int         gap;
    } msg_word_t;

    typedef struct {
        word_t      dword;
        logic [2:0] index;
        logic       dlast;
    } digest_item_t;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    ripemd160_hash_core dut (.*);

    // digest model state
    word_t            hash_state [5];
    word_t            msg_block [16];
    int unsigned      block_pos;
    logic [LEN_W-1:0] msg_bytes;

    msg_word_t    word_queue [$];
    digest_item_t digest_queue [$];
    int           error_count = 0;
    longint       cycle_count = 0;
    bit           stim_done = 0;
    bit           hold_output = 0;
    bit           in_taken = 0;
    int           hold_cycles = 0;
    int           out_wait = 0;
    int           in_wait = 0;

    // tables are duplicated locally so the model does not take them from the package
    localparam logic [3:0] W_L [80] = '{
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
        7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
        3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
        1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
        4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
    localparam logic [3:0] W_R [80] = '{
        5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
        6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
        15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
        8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
        12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
    localparam int SH_L [80] = '{
        11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
        7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
        11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
        11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
        9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
    localparam int SH_R [80] = '{
        8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
        9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
        9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
        15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
        8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
    localparam word_t C_L [5] = '{32'h0, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc,
                                  32'ha953fd4e};
    localparam word_t C_R [5] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                  32'h7a6d76e9, 32'h0};
    localparam word_t START_VALUE [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                          32'h10325476, 32'hc3d2e1f0};

    function automatic word_t rol32(word_t v, int n);
        return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
    endfunction

    function automatic word_t bool_fn(int g, word_t x, word_t y, word_t z);
        case (g)
            0:       return x ^ y ^ z;
            1:       return (x & y) | (~x & z);
            2:       return (x | ~y) ^ z;
            3:       return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    // one compression of msg_block into hash_state
    task automatic compress_model();
        word_t al, bl, cl, dl, el, ar, br, cr, dr, er, t;
        int g;
        al = hash_state[0]; bl = hash_state[1]; cl = hash_state[2];
        dl = hash_state[3]; el = hash_state[4];
        ar = al; br = bl; cr = cl; dr = dl; er = el;
        for (int j = 0; j < 80; j++)
        begin
            g = j / 16;
            t = rol32(al + bool_fn(g, bl, cl, dl) + msg_block[W_L[j]] + C_L[g], SH_L[j]) + el;
            al = el; el = dl; dl = rol32(cl, 10); cl = bl; bl = t;
            t = rol32(ar + bool_fn(4 - g, br, cr, dr) + msg_block[W_R[j]] + C_R[g], SH_R[j])
                + er;
            ar = er; er = dr; dr = rol32(cr, 10); cr = br; br = t;
        end
        t = hash_state[1] + cl + dr;
        hash_state[1] = hash_state[2] + dl + er;
        hash_state[2] = hash_state[3] + el + ar;
        hash_state[3] = hash_state[4] + al + br;
        hash_state[4] = hash_state[0] + bl + cr;
        hash_state[0] = t;
    endtask

    task automatic restart_model();
        hash_state = START_VALUE;
        foreach (msg_block[i]) msg_block[i] = '0;
        block_pos = 0;
        msg_bytes = '0;
    endtask

    // feed one accepted word; on the last word, pad and queue the digest
    task automatic absorb_word(word_t data, logic [2:0] cnt_in, logic last);
        int unsigned cnt, p, idx;
        logic [63:0] bits;
        word_t keep;
        digest_item_t d_item;
        cnt = (!last || cnt_in > FULL_BYTES) ? 4 : cnt_in;
        if (cnt == 4)
        begin
            msg_block[block_pos] = data;
            msg_bytes = msg_bytes + 4;
            block_pos = (block_pos + 1) % 16;
            if (block_pos == 0) compress_model();
            if (!last) return;
            msg_block[block_pos] = '0;
        end
        else
        begin
            keep = (cnt == 0) ? '0 : (32'hffffffff >> (32 - 8 * cnt));
            msg_block[block_pos] = data & keep;
            msg_bytes = msg_bytes + cnt;
        end
        p = msg_bytes[5:0];
        idx = p / 4;
        msg_block[idx] |= 32'h80 << (8 * (p % 4));
        for (int k = idx + 1; k < 16; k++) msg_block[k] = '0;
        if (p > 55)
        begin
            compress_model();
            foreach (msg_block[i]) msg_block[i] = '0;
        end
        bits = {msg_bytes, 3'b000};
        msg_block[14] = bits[31:0];
        msg_block[15] = bits[63:32];
        compress_model();
        for (int k = 0; k < 5; k++)
        begin
            d_item = '{hash_state[k], 3'(k), k == 4};
            digest_queue.insert(digest_queue.size(), d_item);
        end
        restart_model();
    endtask

    task automatic queue_word(word_t d, logic [2:0] c, logic l, int gap);
        msg_word_t w;
        w = '{d, c, l, gap};
        word_queue.insert(word_queue.size(), w);
    endtask

    // message of n words, final word holding cnt bytes
    task automatic queue_message(int n, logic [2:0] cnt, bit gaps);
        for (int i = 0; i < n; i++)
            queue_word($urandom, (i == n - 1) ? cnt : 3'($urandom_range(0, 7)), i == n - 1,
                       gaps ? $urandom_range(0, 16) : 0);
    endtask

    // clock
    always
    begin
        clk = 1'b0; #1;
        clk = 1'b1; #1;
    end

    // driver: presents items at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_word  <= '0;
            byte_count <= '0;
            last_word  <= 1'b0;
            in_wait    <= 0;
        end
        else if (in_valid && !in_taken)
        begin
            // hold payload until taken
        end
        else if (in_wait > 0)
        begin
            in_valid <= 1'b0;
            in_wait  <= in_wait - 1;
        end
        else if (word_queue.size() > 0 && word_queue[0].gap < 0)
        begin
            // sender pause until every digest has come
            in_valid <= 1'b0;
            if (digest_queue.size() == 0) word_queue[0].gap = 0;
        end
        else if (word_queue.size() > 0 && !(in_valid && word_queue[0].gap > 0))
        begin
            msg_word_t w;
            w = word_queue.pop_front();
            in_valid   <= 1'b1;
            data_word  <= w.data;
            byte_count <= w.nbytes;
            last_word  <= w.last;
            if (word_queue.size() > 0 && word_queue[0].gap > 0)
                in_wait <= word_queue[0].gap;
        end
        else if (word_queue.size() > 0)
        begin
            in_valid <= 1'b0;
            in_wait  <= word_queue[0].gap - 1;
            word_queue[0].gap = 0;
        end
        else
            in_valid <= 1'b0;
    end

    // accept side of the input: update the model at the rising edge
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            absorb_word(data_word, byte_count, last_word);
    end

    // receiver stall at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait  <= 0;
        end
        else if (hold_output || hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
        end
        else if (out_wait > 0)
        begin
            out_stall <= 1'b1;
            out_wait  <= out_wait - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: digest item %h idx %0d with nothing expected",
                         $time, digest_word, word_index);
                error_count <= error_count + 1;
            end
            else
            begin
                digest_item_t e;
                e = digest_queue.pop_front();
                if (e.dword !== digest_word || e.index !== word_index
                    || e.dlast !== digest_last)
                begin
                    $display("%0t: expected %h/%0d/%0d got %h/%0d/%0d", $time,
                             e.dword, e.index, e.dlast, digest_word, word_index,
                             digest_last);
                    error_count <= error_count + 1;
                end
            end
            out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ripemd160_hash_core_test: errors");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [2:0] c;
        rst_n = 1'b0;
        restart_model();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, single partial words, extremes of data
        queue_word(32'hffffffff, 3'd0, 1'b1, 0);
        queue_word(32'h00000000, 3'd4, 1'b1, 0);
        queue_word(32'hffffffff, 3'd1, 1'b1, 0);
        queue_word(32'h61626364, 3'd3, 1'b1, 0);
        queue_word(32'hffffffff, 3'd7, 1'b1, 0);
        queue_word(32'hffffffff, 3'd5, 0, 0);
        queue_word(32'h12345678, 3'd2, 1'b1, 0);
        // padding spills into a second block or just fits (14, 14 and 16 words)
        queue_message(14, 3'd4, 0);
        queue_message(14, 3'd1, 0);
        queue_message(16, 3'd4, 0);

        // long receiver hold while sender keeps offering
        wait (word_queue.size() == 0 && digest_queue.size() == 0);
        hold_output = 1'b1;
        hold_cycles = 400;
        hold_output = 1'b0;
        queue_message(3, 3'd2, 0);
        queue_message(2, 3'd4, 0);
        queue_message(20, 3'd3, 0);
        // sender pause until all digests are back
        queue_word($urandom, 3'd4, 1'b1, -1);

        // random messages, mostly short, some spanning blocks
        for (int n_words = 0; n_words < 330; )
        begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 16);
            c = 3'($urandom_range(0, 7));
            queue_message(len, c, $urandom_range(0, 3) != 0);
            n_words += len;
        end

        wait (word_queue.size() == 0);
        @(negedge clk);
        wait (!in_valid && digest_queue.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("ripemd160_hash_core_test: clean");
        else
            $display("ripemd160_hash_core_test: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rmd_pkg.sv
rtl/rmd_front.sv
rtl/rmd_comp.sv
rtl/rmd_back.sv
rtl/ripemd160_hash_core.sv
bench/ripemd160_hash_core_test.sv
